// ----- design/adam_pkg.sv -----
package adam_pkg;

    localparam int MAX_ELEMS = 4096;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int ADDR_W    = 4;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LR  = 2'd0;
    localparam logic [1:0] REG_B1  = 2'd1;
    localparam logic [1:0] REG_B2  = 2'd2;
    localparam logic [1:0] REG_EPS = 2'd3;

    localparam logic [31:0] LR_RST  = 32'd4294967;
    localparam logic [31:0] B1_RST  = 32'd3865470566;
    localparam logic [31:0] B2_RST  = 32'd4290672329;
    localparam logic [31:0] EPS_RST = 32'd43;

    localparam logic [1:0] ACT_UPDATE  = 2'd0;
    localparam logic [1:0] ACT_CLEAR   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [47:0] V_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
    localparam logic [32:0] STEP_CAP = 33'h1_0000_0000;

    // multiplier operand selects
    localparam logic [3:0] MUL_M   = 4'd0;
    localparam logic [3:0] MUL_G2  = 4'd1;
    localparam logic [3:0] MUL_VLO = 4'd2;
    localparam logic [3:0] MUL_VHI = 4'd3;
    localparam logic [3:0] MUL_GLO = 4'd4;
    localparam logic [3:0] MUL_GHI = 4'd5;
    localparam logic [3:0] MUL_SLO = 4'd6;
    localparam logic [3:0] MUL_SHI = 4'd7;
    localparam logic [3:0] MUL_P1  = 4'd8;
    localparam logic [3:0] MUL_P2  = 4'd9;

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_ADDH = 2'd3;

    localparam logic [1:0] DIV_MHAT = 2'd0;
    localparam logic [1:0] DIV_VHAT = 2'd1;
    localparam logic [1:0] DIV_STEP = 2'd2;

    localparam int DIV_NUM_W = 96;
    localparam int DIV_DEN_W = 41;
    localparam int DIV_Q_W   = 64;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int SQ_IN_W   = 80;
    localparam int SQ_ROOT_W = SQ_IN_W / 2;
    localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W + 1);

    typedef struct packed {
        logic [1:0]         action;
        logic [11:0]        element_index;
        logic signed [31:0] param_value;
        logic signed [31:0] gradient;
        logic               last_of_pass;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_param;
        logic [11:0]        index_echo;
        logic               pass_done;
    } result_t;

    typedef struct packed {
        logic [31:0] learning_rate;
        logic [31:0] beta_one;
        logic [31:0] beta_two;
        logic [31:0] epsilon_term;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       elem_clr;
        logic [3:0] mul_sel;
        logic [1:0] acc_op;
        logic       m_upd;
        logic       g2_cap;
        logic       v_upd;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mhat_cap;
        logic       vhat_cap;
        logic       sqrt_start;
        logic       step_cap;
        logic       res_upd;
        logic       pw_restart;
        logic       p1_upd;
        logic       p2_upd;
        logic       done_set;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
        logic sqrt_busy;
        logic last;
    } sts_t;

endpackage

// ----- design/adam_optimizer_update.sv -----
// Adam optimizer update engine. Each transfer on the item channel carries an action,
// an element index, the parameter value and its gradient (Q8.24); exactly one result
// transfer follows per item with the new value (or the value unchanged for clear,
// restart and unused actions), the echoed index and a flag set when the beta powers
// advanced. In an update the bit-serial divider works 64, 80 and 96 iterations for
// the bias-corrected first moment, the corrected second moment and the step, and the
// 40-step square root unit runs in between. A stalled result delays the handoff of
// the next result. One item is in work at a time, and the next item is taken while
// the previous result waits at the output. After reset all 4096 entries of the moment
// store are swept to zero, one entry per cycle, while no item is taken; register
// writes are taken meanwhile.
module adam_optimizer_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  adam_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output adam_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adam_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import adam_pkg::*;

    logic [31:0] lr_reg;
    logic [31:0] b1_reg;
    logic [31:0] b2_reg;
    logic [31:0] eps_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;
    cfg_t        cfg;
    cmd_t        cmd;
    sts_t        sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RST;
            b1_reg  <= B1_RST;
            b2_reg  <= B2_RST;
            eps_reg <= EPS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LR:  lr_reg  <= pwdata;
                REG_B1:  b1_reg  <= pwdata;
                REG_B2:  b2_reg  <= pwdata;
                REG_EPS: eps_reg <= pwdata;
                default: lr_reg  <= lr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LR:  prdata = lr_reg;
            REG_B1:  prdata = b1_reg;
            REG_B2:  prdata = b2_reg;
            REG_EPS: prdata = eps_reg;
            default: prdata = '0;
        endcase
    end

    assign cfg.learning_rate = lr_reg;
    assign cfg.beta_one      = b1_reg;
    assign cfg.beta_two      = b2_reg;
    assign cfg.epsilon_term  = eps_reg;

    adam_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .action       (item.action),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    adam_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

// ----- design/adam_div.sv -----
module adam_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [adam_pkg::DIV_NUM_W-1:0] num,
    input  logic [adam_pkg::DIV_DEN_W-1:0] den,
    input  logic [adam_pkg::DIV_CNT_W-1:0] nbits,
    output logic                           busy,
    output logic [adam_pkg::DIV_Q_W-1:0]   quo,
    output logic                           ovf
);
    import adam_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic                 ovf_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    // restoring division, one quotient bit per cycle, numerator MSB first
    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = nbits;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[DIV_Q_W-1];
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

// ----- design/adam_sqrt.sv -----
module adam_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [adam_pkg::SQ_IN_W-1:0]   rad,
    output logic                           busy,
    output logic [adam_pkg::SQ_ROOT_W-1:0] root
);
    import adam_pkg::*;

    logic                 busy_reg, busy_next;
    logic [SQ_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SQ_IN_W-1:0]   rad_reg;
    logic [SQ_ROOT_W+1:0] rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;
    logic [SQ_ROOT_W+3:0] r2;
    logic [SQ_ROOT_W+3:0] trial;
    logic [SQ_ROOT_W+3:0] diff;
    logic                 ge;

    // digit-by-digit root, two radicand bits per step
    assign r2    = {rem_reg, rad_reg[SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign diff  = r2 - trial;
    assign ge    = (r2 >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SQ_CNT_W'(SQ_ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SQ_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[SQ_ROOT_W+1:0] : r2[SQ_ROOT_W+1:0];
            root_reg <= {root_reg[SQ_ROOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ----- design/adam_dp.sv -----
module adam_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  adam_pkg::cfg_t    cfg,
    input  adam_pkg::item_t   item,
    input  adam_pkg::cmd_t    cmd,
    output adam_pkg::sts_t    sts,
    output adam_pkg::result_t result
);
    import adam_pkg::*;

    logic [31:0] m_mem [MAX_ELEMS];
    logic [47:0] v_mem [MAX_ELEMS];

    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [11:0]      echo_reg;
    logic [31:0]      p_reg;
    logic [31:0]      g_reg;
    logic             last_reg;
    logic [31:0]      m_old_reg;
    logic [47:0]      v_old_reg;
    logic [65:0]      prod_reg;
    logic             d_neg_reg;
    logic [95:0]      acc_reg;
    logic [31:0]      m_reg;
    logic [46:0]      g2_reg;
    logic [47:0]      v_reg;
    logic [63:0]      mhat_reg;
    logic [47:0]      vhat_reg;
    logic [32:0]      step_reg;
    logic [31:0]      res_reg;
    logic             done_reg;
    logic [31:0]      b1p_reg;
    logic [31:0]      b2p_reg;
    result_t          out_reg;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic [31:0]          mem_wm;
    logic [47:0]          mem_wv;
    logic [32:0]          d_val;
    logic [32:0]          d_mag;
    logic [31:0]          g_mag;
    logic [32:0]          c2;
    logic [32:0]          mul_a;
    logic [32:0]          mul_b;
    logic [66:0]          p_ext;
    logic [66:0]          m_sum;
    logic [47:0]          v_sat;
    logic [31:0]          m_mag;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_CNT_W-1:0] div_nbits;
    logic [DIV_DEN_W-1:0] den_raw;
    logic [DIV_DEN_W-1:0] den_val;
    logic                 div_busy;
    logic [DIV_Q_W-1:0]   div_quo;
    logic                 div_ovf;
    logic                 sqrt_busy;
    logic [SQ_ROOT_W-1:0] sqrt_root;
    logic [34:0]          upd_sum;
    logic [31:0]          upd_sat;

    // moment store; clearing pass, element clear and update share one write port
    assign mem_we = cmd.clr_wr | cmd.elem_clr | cmd.v_upd;
    assign mem_wa = cmd.clr_wr ? clr_cnt_reg : idx_reg;
    assign mem_wm = cmd.v_upd ? m_reg : '0;
    assign mem_wv = cmd.v_upd ? v_sat : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            m_mem[mem_wa] <= mem_wm;
            v_mem[mem_wa] <= mem_wv;
        end
        if (cmd.load)
        begin
            m_old_reg <= m_mem[item.element_index[IDX_W-1:0]];
            v_old_reg <= v_mem[item.element_index[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            b1p_reg     <= B1_RST;
            b2p_reg     <= B2_RST;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.pw_restart)
            begin
                b1p_reg <= cfg.beta_one;
                b2p_reg <= cfg.beta_two;
            end
            else
            begin
                if (cmd.p1_upd)
                begin
                    b1p_reg <= prod_reg[63:32];
                end
                if (cmd.p2_upd)
                begin
                    b2p_reg <= prod_reg[63:32];
                end
            end
        end
    end

    // m = g + b1*(m_old - g) in Q.32 scale; the difference goes through as a magnitude
    assign d_val = {m_old_reg[31], m_old_reg} - {g_reg[31], g_reg};
    assign d_mag = d_val[32] ? (~d_val + 1'b1) : d_val;
    assign g_mag = g_reg[31] ? (~g_reg + 1'b1) : g_reg;
    assign c2    = ONE_Q32 - {1'b0, cfg.beta_two};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_M:
            begin
                mul_a = {1'b0, cfg.beta_one};
                mul_b = d_mag;
            end
            MUL_G2:
            begin
                mul_a = {1'b0, g_mag};
                mul_b = {1'b0, g_mag};
            end
            MUL_VLO:
            begin
                mul_a = {1'b0, v_old_reg[31:0]};
                mul_b = {1'b0, cfg.beta_two};
            end
            MUL_VHI:
            begin
                mul_a = {17'b0, v_old_reg[47:32]};
                mul_b = {1'b0, cfg.beta_two};
            end
            MUL_GLO:
            begin
                mul_a = {1'b0, g2_reg[31:0]};
                mul_b = c2;
            end
            MUL_GHI:
            begin
                mul_a = {18'b0, g2_reg[46:32]};
                mul_b = c2;
            end
            MUL_SLO:
            begin
                mul_a = {1'b0, mhat_reg[31:0]};
                mul_b = {1'b0, cfg.learning_rate};
            end
            MUL_SHI:
            begin
                mul_a = {1'b0, mhat_reg[63:32]};
                mul_b = {1'b0, cfg.learning_rate};
            end
            MUL_P1:
            begin
                mul_a = {1'b0, b1p_reg};
                mul_b = {1'b0, cfg.beta_one};
            end
            MUL_P2:
            begin
                mul_a = {1'b0, b2p_reg};
                mul_b = {1'b0, cfg.beta_two};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p_ext = {1'b0, prod_reg};
    assign m_sum = {{3{g_reg[31]}}, g_reg, 32'b0} + (d_neg_reg ? (~p_ext + 1'b1) : p_ext);
    assign v_sat = (|acc_reg[95:80]) ? V_MAX : acc_reg[79:32];
    assign m_mag = m_reg[31] ? (~m_reg + 1'b1) : m_reg;

    assign den_raw = {1'b0, sqrt_root} + {9'b0, cfg.epsilon_term};
    assign den_val = (den_raw == '0) ? DIV_DEN_W'(1) : den_raw;

    always_comb
    begin
        div_num   = acc_reg;
        div_den   = den_val;
        div_nbits = DIV_CNT_W'(96);
        unique case (cmd.div_sel)
            DIV_MHAT:
            begin
                div_num   = {m_mag, 64'b0};
                div_den   = {8'b0, ONE_Q32 - {1'b0, b1p_reg}};
                div_nbits = DIV_CNT_W'(64);
            end
            DIV_VHAT:
            begin
                div_num   = {v_reg, 48'b0};
                div_den   = {8'b0, ONE_Q32 - {1'b0, b2p_reg}};
                div_nbits = DIV_CNT_W'(80);
            end
            DIV_STEP:
            begin
                div_num   = acc_reg;
                div_den   = den_val;
                div_nbits = DIV_CNT_W'(96);
            end
            default:
            begin
                div_num   = acc_reg;
                div_den   = den_val;
                div_nbits = DIV_CNT_W'(96);
            end
        endcase
    end

    adam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .nbits (div_nbits),
        .busy  (div_busy),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    adam_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .rad   ({vhat_reg, 32'b0}),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    // step moves against the sign of the first moment
    assign upd_sum = m_reg[31] ? ({{3{p_reg[31]}}, p_reg} + {2'b0, step_reg})
                               : ({{3{p_reg[31]}}, p_reg} - {2'b0, step_reg});

    always_comb
    begin
        if (!upd_sum[34] && (upd_sum[33:31] != 3'b000))
        begin
            upd_sat = 32'h7FFF_FFFF;
        end
        else if (upd_sum[34] && (upd_sum[33:31] != 3'b111))
        begin
            upd_sat = 32'h8000_0000;
        end
        else
        begin
            upd_sat = upd_sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.mul_sel == MUL_M)
        begin
            d_neg_reg <= d_val[32];
        end
        if (cmd.load)
        begin
            idx_reg  <= item.element_index[IDX_W-1:0];
            echo_reg <= item.element_index;
            p_reg    <= item.param_value;
            g_reg    <= item.gradient;
            last_reg <= item.last_of_pass;
            res_reg  <= item.param_value;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.res_upd)
            begin
                res_reg <= upd_sat;
            end
            if (cmd.done_set)
            begin
                done_reg <= 1'b1;
            end
        end
        unique case (cmd.acc_op)
            ACC_HOLD: acc_reg <= acc_reg;
            ACC_LOAD: acc_reg <= {30'b0, prod_reg};
            ACC_ADD:  acc_reg <= acc_reg + {30'b0, prod_reg};
            ACC_ADDH: acc_reg <= acc_reg + {prod_reg[63:0], 32'b0};
            default:  acc_reg <= acc_reg;
        endcase
        if (cmd.m_upd)
        begin
            m_reg <= m_sum[63:32];
        end
        // g*g reaches 2^62 for the most negative gradient, so g2 keeps 47 bits
        if (cmd.g2_cap)
        begin
            g2_reg <= prod_reg[62:16];
        end
        if (cmd.v_upd)
        begin
            v_reg <= v_sat;
        end
        if (cmd.mhat_cap)
        begin
            mhat_reg <= div_quo;
        end
        if (cmd.vhat_cap)
        begin
            vhat_reg <= (div_ovf || (|div_quo[63:48])) ? V_MAX : div_quo[47:0];
        end
        if (cmd.step_cap)
        begin
            step_reg <= (div_ovf || (div_quo > {31'b0, STEP_CAP})) ? STEP_CAP
                                                                   : div_quo[32:0];
        end
        if (cmd.out_load)
        begin
            out_reg <= {res_reg, echo_reg, done_reg};
        end
    end

    assign sts.clr_last  = (clr_cnt_reg == IDX_W'(MAX_ELEMS - 1));
    assign sts.div_busy  = div_busy;
    assign sts.sqrt_busy = sqrt_busy;
    assign sts.last      = last_reg;
    assign result        = out_reg;

endmodule

// ----- design/adam_ctrl.sv -----
module adam_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [1:0]       action,
    output logic             item_stall,
    output logic             result_valid,
    input  logic             result_stall,
    input  adam_pkg::sts_t   sts,
    output adam_pkg::cmd_t   cmd
);
    import adam_pkg::*;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_M1    = 5'd2;
    localparam logic [4:0] S_M2    = 5'd3;
    localparam logic [4:0] S_V1    = 5'd4;
    localparam logic [4:0] S_V2    = 5'd5;
    localparam logic [4:0] S_V3    = 5'd6;
    localparam logic [4:0] S_V4    = 5'd7;
    localparam logic [4:0] S_V5    = 5'd8;
    localparam logic [4:0] S_V6    = 5'd9;
    localparam logic [4:0] S_W_MH  = 5'd10;
    localparam logic [4:0] S_W_VH  = 5'd11;
    localparam logic [4:0] S_S1    = 5'd12;
    localparam logic [4:0] S_S2    = 5'd13;
    localparam logic [4:0] S_S3    = 5'd14;
    localparam logic [4:0] S_W_SQ  = 5'd15;
    localparam logic [4:0] S_W_ST  = 5'd16;
    localparam logic [4:0] S_RES   = 5'd17;
    localparam logic [4:0] S_P1    = 5'd18;
    localparam logic [4:0] S_P2    = 5'd19;
    localparam logic [4:0] S_P3    = 5'd20;
    localparam logic [4:0] S_ELCLR = 5'd21;
    localparam logic [4:0] S_RSTPW = 5'd22;
    localparam logic [4:0] S_FIN   = 5'd23;

    logic [4:0] state_reg, state_next;
    logic       rv_reg, rv_next;
    logic       take;

    assign take       = item_valid && (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.load = 1'b1;
                    priority case (action)
                        ACT_UPDATE:  state_next = S_M1;
                        ACT_CLEAR:   state_next = S_ELCLR;
                        ACT_RESTART: state_next = S_RSTPW;
                        default:     state_next = S_FIN;
                    endcase
                end
            end
            S_M1:
            begin
                cmd.mul_sel = MUL_M;
                state_next  = S_M2;
            end
            S_M2:
            begin
                cmd.m_upd   = 1'b1;
                cmd.mul_sel = MUL_G2;
                state_next  = S_V1;
            end
            S_V1:
            begin
                cmd.g2_cap  = 1'b1;
                cmd.mul_sel = MUL_VLO;
                state_next  = S_V2;
            end
            S_V2:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_VHI;
                state_next  = S_V3;
            end
            S_V3:
            begin
                cmd.acc_op  = ACC_ADDH;
                cmd.mul_sel = MUL_GLO;
                state_next  = S_V4;
            end
            S_V4:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_sel = MUL_GHI;
                state_next  = S_V5;
            end
            S_V5:
            begin
                cmd.acc_op = ACC_ADDH;
                state_next = S_V6;
            end
            S_V6:
            begin
                cmd.v_upd     = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MHAT;
                state_next    = S_W_MH;
            end
            S_W_MH:
            begin
                cmd.div_sel = DIV_VHAT;
                if (!sts.div_busy)
                begin
                    cmd.mhat_cap  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_W_VH;
                end
            end
            S_W_VH:
            begin
                if (!sts.div_busy)
                begin
                    cmd.vhat_cap = 1'b1;
                    state_next   = S_S1;
                end
            end
            S_S1:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.mul_sel    = MUL_SLO;
                state_next     = S_S2;
            end
            S_S2:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_SHI;
                state_next  = S_S3;
            end
            S_S3:
            begin
                cmd.acc_op = ACC_ADDH;
                state_next = S_W_SQ;
            end
            S_W_SQ:
            begin
                cmd.div_sel = DIV_STEP;
                if (!sts.sqrt_busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_W_ST;
                end
            end
            S_W_ST:
            begin
                if (!sts.div_busy)
                begin
                    cmd.step_cap = 1'b1;
                    state_next   = S_RES;
                end
            end
            S_RES:
            begin
                cmd.res_upd = 1'b1;
                state_next  = sts.last ? S_P1 : S_FIN;
            end
            S_P1:
            begin
                cmd.mul_sel = MUL_P1;
                state_next  = S_P2;
            end
            S_P2:
            begin
                cmd.p1_upd  = 1'b1;
                cmd.mul_sel = MUL_P2;
                state_next  = S_P3;
            end
            S_P3:
            begin
                cmd.p2_upd   = 1'b1;
                cmd.done_set = 1'b1;
                state_next   = S_FIN;
            end
            S_ELCLR:
            begin
                cmd.elem_clr = 1'b1;
                state_next   = S_FIN;
            end
            S_RSTPW:
            begin
                cmd.pw_restart = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                // hand off only when the output slot is empty or drains now
                if (!rv_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rv_next = rv_reg;
        if (cmd.out_load)
        begin
            rv_next = 1'b1;
        end
        else if (!result_stall)
        begin
            rv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    assign result_valid = rv_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_sqrt_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |-> !sts.sqrt_busy)
        else $error("root unit started while busy");

    a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg != S_IDLE))
        else $error("transfer taken but sequencer stayed idle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> !$past(cmd.out_load))
        else $error("pending result overwritten");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

import adam_pkg::*;

class adam_scoreboard;
    logic signed [31:0] m_store [MAX_ELEMS];
    logic [47:0]        v_store [MAX_ELEMS];
    logic [31:0]        pow_one, pow_two;
    cfg_t               cfg;
    result_t            expected_q [$];
    int                 mismatches;
    int                 checked;
    int                 updates;
    int                 passes;

    function new();
        foreach (m_store[i])
        begin
            m_store[i] = '0;
            v_store[i] = '0;
        end
        cfg.learning_rate = LR_RST;
        cfg.beta_one      = B1_RST;
        cfg.beta_two      = B2_RST;
        cfg.epsilon_term  = EPS_RST;
        pow_one = B1_RST;
        pow_two = B2_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            REG_LR:  cfg.learning_rate = val;
            REG_B1:  cfg.beta_one      = val;
            REG_B2:  cfg.beta_two      = val;
            default: cfg.epsilon_term  = val;
        endcase
    endfunction

    function logic [63:0] isqrt(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 40; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x)
                r = c;
        end
        return r;
    endfunction

    // Adam step for one transfer; updates moments and powers
    function void note(item_t it);
        result_t            r;
        logic signed [95:0] acc;
        logic signed [63:0] m;
        logic signed [63:0] g;
        logic [63:0]        gm, mm, g2, mhat, vhat, den, root;
        logic [127:0]       vs, num, q;
        logic signed [63:0] res;
        int                 idx;
        r.new_param  = it.param_value;
        r.index_echo = it.element_index;
        r.pass_done  = 1'b0;
        idx = it.element_index;
        if (it.action == ACT_UPDATE)
        begin
            updates++;
            g = it.gradient;
            acc = $signed({64'd0, cfg.beta_one}) * $signed(m_store[idx])
                + $signed({63'd0, 33'h1_0000_0000 - cfg.beta_one}) * g;
            m = acc[95:32];
            gm = (g < 0) ? -g : g;
            g2 = (gm * gm) >> 16;
            vs = {80'd0, v_store[idx]} * {96'd0, cfg.beta_two}
               + {64'd0, g2} * {95'd0, 33'h1_0000_0000 - cfg.beta_two};
            vs = vs >> 32;
            m_store[idx] = m[31:0];
            v_store[idx] = (vs > {80'd0, V_MAX}) ? V_MAX : vs[47:0];
            mm = (m < 0) ? -m : m;
            num = {64'd0, mm} << 32;
            q = num / {95'd0, 33'h1_0000_0000 - pow_one};
            mhat = q[63:0];
            num = {80'd0, v_store[idx]} << 32;
            q = num / {95'd0, 33'h1_0000_0000 - pow_two};
            vhat = (q > {80'd0, V_MAX}) ? {16'd0, V_MAX} : q[63:0];
            root = isqrt({64'd0, vhat} << 32);
            den = root + cfg.epsilon_term;
            if (den == 0)
                den = 1;
            q = ({64'd0, mhat} * {96'd0, cfg.learning_rate}) / {64'd0, den};
            if (q > 128'h1_0000_0000)
                q = 128'h1_0000_0000;
            res = (m < 0) ? 64'(it.param_value) + $signed(q[63:0])
                          : 64'(it.param_value) - $signed(q[63:0]);
            if (res > 64'sd2147483647)
                res = 64'sd2147483647;
            if (res < -64'sd2147483648)
                res = -64'sd2147483648;
            r.new_param = res[31:0];
            if (it.last_of_pass)
            begin
                pow_one = 32'((64'(pow_one) * 64'(cfg.beta_one)) >> 32);
                pow_two = 32'((64'(pow_two) * 64'(cfg.beta_two)) >> 32);
                r.pass_done = 1'b1;
                passes++;
            end
        end
        else if (it.action == ACT_CLEAR)
        begin
            m_store[idx] = '0;
            v_store[idx] = '0;
        end
        else if (it.action == ACT_RESTART)
        begin
            pow_one = cfg.beta_one;
            pow_two = cfg.beta_two;
        end
        expected_q.push_back(r);
    endfunction

    function void check(result_t got);
        result_t exp_r;
        checked++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transfer: %h", got);
            return;
        end
        exp_r = expected_q.pop_front();
        if (got !== exp_r)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch #%0d: exp param %h idx %0d done %b, got %h %0d %b",
                         checked, exp_r.new_param, exp_r.index_echo, exp_r.pass_done,
                         got.new_param, got.index_echo, got.pass_done);
        end
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 40000;
    localparam int DRAIN_WAIT  = 400;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    adam_scoreboard sb;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  item_taken;
    int  quiet_cycles;

    adam_optimizer_update uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < rcv_idle_pct);

    // sample both channels mid-cycle where everything is settled
    always @(negedge clk)
    begin
        item_taken = item_valid && !item_stall;
        if (item_taken)
            sb.note(item);
        if (result_valid && !result_stall)
            sb.check(result);
        if (item_taken || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", sb.expected_q.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_cfg(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2,
                            logic [31:0] eps);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        reg_write(REG_LR, lr);
        reg_write(REG_B1, b1);
        reg_write(REG_B2, b2);
        reg_write(REG_EPS, eps);
    endtask

    task automatic send(logic [1:0] act, logic [11:0] idx, logic [31:0] p,
                        logic [31:0] g, logic last);
        item_t it;
        it.action        = act;
        it.element_index = idx;
        it.param_value   = p;
        it.gradient      = g;
        it.last_of_pass  = last;
        @(posedge clk);
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_taken);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(posedge clk);
        end
        else
            item_valid <= 1'b0;
    endtask

    task automatic random_items(int count);
        logic [1:0]  act;
        logic [11:0] idx;
        logic [31:0] g;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 86)
                act = ACT_UPDATE;
            else if (pick < 92)
                act = ACT_CLEAR;
            else if (pick < 96)
                act = ACT_RESTART;
            else
                act = 2'd3;
            // a small working set lets the moments build up over many steps
            idx = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
            g = $urandom;
            if ($urandom_range(1))
                g = $signed(g) >>> $urandom_range(4, 20);
            send(act, idx, $urandom, g, $urandom_range(19) == 0);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        item_taken = 1'b0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults, field extremes, every action
        load_cfg(LR_RST, B1_RST, B2_RST, EPS_RST);
        send(ACT_UPDATE, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send(ACT_UPDATE, 12'd4095, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send(ACT_UPDATE, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send(ACT_UPDATE, 12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send(ACT_UPDATE, 12'd1, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send(ACT_UPDATE, 12'd2, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
        send(ACT_UPDATE, 12'd2, 32'h0100_0000, 32'hFFFF_FFFF, 1'b0);
        send(ACT_CLEAR, 12'd0, 32'h1234_5678, 32'h7FFF_FFFF, 1'b1);
        send(ACT_UPDATE, 12'd0, 32'h0000_0000, 32'h0100_0000, 1'b0);
        send(ACT_RESTART, 12'hABC, 32'h8000_0000, 32'h0, 1'b1);
        send(2'd3, 12'h555, 32'hDEAD_BEEF, 32'h8000_0000, 1'b1);
        send(ACT_UPDATE, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        send(ACT_UPDATE, 12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);

        // lowest first decay, full second decay, no epsilon
        load_cfg(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send(ACT_RESTART, 12'd7, 32'h0, 32'h0, 1'b0);
        send(ACT_CLEAR, 12'd7, 32'h0, 32'h0, 1'b0);
        // root and epsilon both zero
        send(ACT_UPDATE, 12'd7, 32'h0100_0000, 32'h0, 1'b0);
        send(ACT_UPDATE, 12'd8, 32'h7FFF_FFFF, 32'hFFFF_FF00, 1'b1);
        send(ACT_UPDATE, 12'd8, 32'h8000_0000, 32'h0000_0100, 1'b0);

        snd_idle_pct = 13;
        rcv_idle_pct = 68;
        load_cfg($urandom, $urandom, $urandom, $urandom_range(1000));
        send(ACT_RESTART, 12'd0, 32'h0, 32'h0, 1'b0);
        random_items(350);

        snd_idle_pct = 68;
        rcv_idle_pct = 13;
        load_cfg(32'h0800_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send(ACT_RESTART, 12'd0, 32'h0, 32'h0, 1'b0);
        random_items(150);
        load_cfg(32'h0000_0000, 32'hE666_6666, 32'hFFBE_76C9, 32'h0);
        send(ACT_RESTART, 12'd0, 32'h0, 32'h0, 1'b0);
        random_items(200);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        load_cfg(LR_RST, B1_RST, B2_RST, EPS_RST);
        random_items(330);

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("checked %0d results: %0d updates, %0d beta power advances",
                 sb.checked, sb.updates, sb.passes);
        $display("register settings included all-zero and all-one extremes; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
